FILE: rtl/hpc_pkg.sv
// ----------------------------------------------------------------------------
// hpc_pkg
// Shared widths, codes and types of the heater PID / hysteresis controller.
// ----------------------------------------------------------------------------
package hpc_pkg;

    localparam int TEMP_W  = 15;   // temperatures, 1/16 degree
    localparam int GAIN_W  = 8;    // Q4.4 gains
    localparam int BAND_W  = 10;
    localparam int ERR_W   = 16;
    localparam int DERIV_W = 17;
    localparam int SUM_W   = 24;
    localparam int DRIVE_W = 24;
    localparam int RAW_W   = 34;
    localparam int CMP_W   = 17;   // width for temperature threshold compares
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // input op codes
    localparam logic [OP_W-1:0] OP_SAMPLE   = 2'd0;
    localparam logic [OP_W-1:0] OP_TOUCH    = 2'd1;
    localparam logic [OP_W-1:0] OP_HEAT_ON  = 2'd2;
    localparam logic [OP_W-1:0] OP_HEAT_OFF = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_TEMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_ON      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_OFF     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REARM_ENABLE = 3'd6;

    // register reset values
    localparam logic signed [TEMP_W-1:0] RST_GOAL_TEMP = '0;
    localparam logic [GAIN_W-1:0] RST_GAIN_P   = 8'd19;
    localparam logic [GAIN_W-1:0] RST_GAIN_I   = 8'd11;
    localparam logic [GAIN_W-1:0] RST_GAIN_D   = 8'd38;
    localparam logic [BAND_W-1:0] RST_BAND_ON  = 10'd48;
    localparam logic [BAND_W-1:0] RST_BAND_OFF = 10'd3;

    // raw drive limits, 1/256 degree units: 3.0 and 0.01
    localparam logic signed [RAW_W-1:0] OFF_LIMIT = RAW_W'(768);
    localparam logic signed [RAW_W-1:0] ON_LIMIT  = RAW_W'(2);

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

    // classified command, front to back
    typedef struct packed {
        logic                     sample;
        logic                     load_temp;
        logic                     touch;
        logic                     touch_level;
        logic                     set_heat;
        logic                     clr_heat;
        logic signed [TEMP_W-1:0] temp;
    } t_cmd;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

FILE: rtl/hpc_front.sv
// ----------------------------------------------------------------------------
// hpc_front
// Input side: takes items from the input channel and decodes them into commands.
// ----------------------------------------------------------------------------
module hpc_front (
    input  logic                              i_in_valid,
    input  logic [hpc_pkg::OP_W-1:0]          i_op,
    input  logic signed [hpc_pkg::TEMP_W-1:0] i_temp_sample,
    input  logic                              i_read_ok,
    input  logic                              i_touch_level,
    input  logic                              i_q_full,
    output logic                              o_in_stall,
    output logic                              o_push,
    output hpc_pkg::t_cmd                     o_cmd
);

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;

    always_comb begin
        o_cmd             = '0;
        o_cmd.temp        = i_temp_sample;
        o_cmd.touch_level = i_touch_level;
        unique case (i_op)
            hpc_pkg::OP_SAMPLE: begin
                o_cmd.sample    = 1'b1;
                o_cmd.load_temp = i_read_ok;
            end
            hpc_pkg::OP_TOUCH:    o_cmd.touch    = 1'b1;
            hpc_pkg::OP_HEAT_ON:  o_cmd.set_heat = 1'b1;
            hpc_pkg::OP_HEAT_OFF: o_cmd.clr_heat = 1'b1;
            default:              o_cmd.clr_heat = 1'b1;
        endcase
    end

endmodule

FILE: rtl/hpc_queue.sv
// ----------------------------------------------------------------------------
// hpc_queue
// Two-entry command queue between the front and the execution back end.
// ----------------------------------------------------------------------------
module hpc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hpc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output hpc_pkg::t_cmd o_cmd
);

    hpc_pkg::t_cmd r_entry [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          n_wr_ptr;
    logic          n_rd_ptr;
    logic [1:0]    n_count;

    assign o_full  = r_count[1];
    assign o_valid = |r_count;
    assign o_cmd   = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/hpc_back.sv
// ----------------------------------------------------------------------------
// hpc_back
// Execution side: registers, PID step, hysteresis and touch logic, result port.
// ----------------------------------------------------------------------------
module hpc_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  hpc_pkg::t_cfg_wr                   i_cfg,
    input  logic                               i_q_valid,
    input  hpc_pkg::t_cmd                      i_cmd,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_heater_on,
    output logic signed [hpc_pkg::DRIVE_W-1:0] o_drive_value,
    output logic                               o_loop_enabled,
    output logic signed [hpc_pkg::TEMP_W-1:0]  o_current_temp
);

    // configuration registers
    logic signed [hpc_pkg::TEMP_W-1:0] r_goal;
    logic [hpc_pkg::GAIN_W-1:0]        r_gain_p;
    logic [hpc_pkg::GAIN_W-1:0]        r_gain_i;
    logic [hpc_pkg::GAIN_W-1:0]        r_gain_d;
    logic [hpc_pkg::BAND_W-1:0]        r_band_on;
    logic [hpc_pkg::BAND_W-1:0]        r_band_off;
    logic                              r_rearm;

    // controller state
    logic                               r_heat,       n_heat;
    logic                               r_loop,       n_loop;
    logic                               r_prior_touch, n_prior_touch;
    logic signed [hpc_pkg::TEMP_W-1:0]  r_last_temp,  n_last_temp;
    logic signed [hpc_pkg::TEMP_W-1:0]  r_past_temp,  n_past_temp;
    logic signed [hpc_pkg::SUM_W-1:0]   r_error_sum,  n_error_sum;
    logic signed [hpc_pkg::ERR_W-1:0]   r_prior_error, n_prior_error;
    logic signed [hpc_pkg::DRIVE_W-1:0] r_last_drive, n_last_drive;
    logic                               r_out_valid,  n_out_valid;

    logic                               w_take;
    logic signed [hpc_pkg::TEMP_W-1:0]  w_temp;
    logic signed [hpc_pkg::ERR_W-1:0]   w_error;
    logic signed [hpc_pkg::SUM_W:0]     w_sum_wide;
    logic signed [hpc_pkg::SUM_W-1:0]   w_sum;
    logic signed [hpc_pkg::DERIV_W-1:0] w_deriv;
    logic signed [hpc_pkg::ERR_W+hpc_pkg::GAIN_W:0]   w_prod_p;
    logic signed [hpc_pkg::SUM_W+hpc_pkg::GAIN_W:0]   w_prod_i;
    logic signed [hpc_pkg::DERIV_W+hpc_pkg::GAIN_W:0] w_prod_d;
    logic signed [hpc_pkg::RAW_W-1:0]   w_raw;
    logic signed [hpc_pkg::RAW_W-1:0]   w_div;
    logic signed [hpc_pkg::DRIVE_W-1:0] w_drive;
    logic signed [hpc_pkg::CMP_W-1:0]   w_on_lim;
    logic signed [hpc_pkg::CMP_W-1:0]   w_off_lim;
    logic signed [hpc_pkg::CMP_W-1:0]   w_temp_x;
    logic signed [hpc_pkg::CMP_W-1:0]   w_past_x;
    logic                               w_turn_off;
    logic                               w_heat_mid;
    logic                               w_turn_on;
    logic                               w_pid_heat;
    logic                               w_rise;

    assign w_take = i_q_valid & (~r_out_valid | ~i_out_stall);
    assign o_pop  = w_take;

    // PID arithmetic on the temperature this sample leaves behind
    assign w_temp     = i_cmd.load_temp ? i_cmd.temp : r_last_temp;
    assign w_error    = hpc_pkg::ERR_W'(r_goal) - hpc_pkg::ERR_W'(w_temp);
    assign w_sum_wide = (hpc_pkg::SUM_W+1)'(r_error_sum) + (hpc_pkg::SUM_W+1)'(w_error);

    always_comb begin
        if (w_sum_wide[hpc_pkg::SUM_W] == w_sum_wide[hpc_pkg::SUM_W-1]) begin
            w_sum = w_sum_wide[hpc_pkg::SUM_W-1:0];
        end else if (w_sum_wide[hpc_pkg::SUM_W]) begin
            w_sum = hpc_pkg::SUM_MIN;
        end else begin
            w_sum = hpc_pkg::SUM_MAX;
        end
    end

    assign w_deriv  = hpc_pkg::DERIV_W'(w_error) - hpc_pkg::DERIV_W'(r_prior_error);
    assign w_prod_p = $signed({1'b0, r_gain_p}) * w_error;
    assign w_prod_i = $signed({1'b0, r_gain_i}) * w_sum;
    assign w_prod_d = $signed({1'b0, r_gain_d}) * w_deriv;
    assign w_raw    = hpc_pkg::RAW_W'(w_prod_p) + hpc_pkg::RAW_W'(w_prod_i)
                    + hpc_pkg::RAW_W'(w_prod_d);
    // floor division by 16
    assign w_div    = w_raw >>> 4;

    always_comb begin
        if ((&w_div[hpc_pkg::RAW_W-1:hpc_pkg::DRIVE_W-1])
                || !(|w_div[hpc_pkg::RAW_W-1:hpc_pkg::DRIVE_W-1])) begin
            w_drive = w_div[hpc_pkg::DRIVE_W-1:0];
        end else if (w_div[hpc_pkg::RAW_W-1]) begin
            w_drive = hpc_pkg::DRIVE_MIN;
        end else begin
            w_drive = hpc_pkg::DRIVE_MAX;
        end
    end

    // hysteresis: off check first, on check sees its result
    assign w_on_lim   = hpc_pkg::CMP_W'(r_goal)
                      - $signed({{(hpc_pkg::CMP_W-hpc_pkg::BAND_W){1'b0}}, r_band_on});
    assign w_off_lim  = hpc_pkg::CMP_W'(r_goal)
                      - $signed({{(hpc_pkg::CMP_W-hpc_pkg::BAND_W){1'b0}}, r_band_off});
    assign w_temp_x   = hpc_pkg::CMP_W'(w_temp);
    assign w_past_x   = hpc_pkg::CMP_W'(r_past_temp);
    assign w_turn_off = r_heat && (w_temp_x >= w_on_lim) && (w_past_x <= w_temp_x)
                        && (w_raw <= hpc_pkg::OFF_LIMIT);
    assign w_heat_mid = r_heat & ~w_turn_off;
    assign w_turn_on  = !w_heat_mid && (w_temp_x <= w_off_lim) && (w_past_x >= w_temp_x)
                        && (w_raw > hpc_pkg::ON_LIMIT);
    assign w_pid_heat = w_heat_mid | w_turn_on;

    assign w_rise = i_cmd.touch_level & ~r_prior_touch;

    always_comb begin
        n_heat        = r_heat;
        n_loop        = r_loop;
        n_prior_touch = r_prior_touch;
        n_last_temp   = r_last_temp;
        n_past_temp   = r_past_temp;
        n_error_sum   = r_error_sum;
        n_prior_error = r_prior_error;
        n_last_drive  = r_last_drive;
        if (w_take) begin
            priority if (i_cmd.sample) begin
                if (r_loop) begin
                    n_last_temp   = w_temp;
                    n_error_sum   = w_sum;
                    n_last_drive  = w_drive;
                    n_heat        = w_pid_heat;
                    n_prior_error = w_error;
                    n_past_temp   = w_temp;
                end
            end else if (i_cmd.touch) begin
                if (w_rise) begin
                    if (!r_heat) begin
                        n_heat = 1'b1;
                        if (r_rearm) begin
                            n_loop = 1'b1;
                        end
                    end else begin
                        n_heat = 1'b0;
                        n_loop = 1'b0;
                    end
                end
                n_prior_touch = i_cmd.touch_level;
            end else if (i_cmd.set_heat) begin
                n_heat = 1'b1;
            end else begin
                n_heat = 1'b0;
            end
        end
    end

    always_comb begin
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat        <= 1'b0;
            r_loop        <= 1'b1;
            r_prior_touch <= 1'b0;
            r_last_temp   <= '0;
            r_past_temp   <= '0;
            r_error_sum   <= '0;
            r_prior_error <= '0;
            r_last_drive  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_heat        <= n_heat;
            r_loop        <= n_loop;
            r_prior_touch <= n_prior_touch;
            r_last_temp   <= n_last_temp;
            r_past_temp   <= n_past_temp;
            r_error_sum   <= n_error_sum;
            r_prior_error <= n_prior_error;
            r_last_drive  <= n_last_drive;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal     <= hpc_pkg::RST_GOAL_TEMP;
            r_gain_p   <= hpc_pkg::RST_GAIN_P;
            r_gain_i   <= hpc_pkg::RST_GAIN_I;
            r_gain_d   <= hpc_pkg::RST_GAIN_D;
            r_band_on  <= hpc_pkg::RST_BAND_ON;
            r_band_off <= hpc_pkg::RST_BAND_OFF;
            r_rearm    <= 1'b0;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                hpc_pkg::CFG_GOAL_TEMP:    r_goal     <= $signed(i_cfg.data[hpc_pkg::TEMP_W-1:0]);
                hpc_pkg::CFG_GAIN_P:       r_gain_p   <= i_cfg.data[hpc_pkg::GAIN_W-1:0];
                hpc_pkg::CFG_GAIN_I:       r_gain_i   <= i_cfg.data[hpc_pkg::GAIN_W-1:0];
                hpc_pkg::CFG_GAIN_D:       r_gain_d   <= i_cfg.data[hpc_pkg::GAIN_W-1:0];
                hpc_pkg::CFG_BAND_ON:      r_band_on  <= i_cfg.data[hpc_pkg::BAND_W-1:0];
                hpc_pkg::CFG_BAND_OFF:     r_band_off <= i_cfg.data[hpc_pkg::BAND_W-1:0];
                hpc_pkg::CFG_REARM_ENABLE: r_rearm    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // state only moves when a result is taken, so it doubles as the result register
    assign o_out_valid    = r_out_valid;
    assign o_heater_on    = r_heat;
    assign o_drive_value  = r_last_drive;
    assign o_loop_enabled = r_loop;
    assign o_current_temp = r_last_temp;

endmodule

FILE: rtl/heater_pid_hysteresis_control.sv
// ----------------------------------------------------------------------------
// heater_pid_hysteresis_control
// Heater controller with PID drive, hysteresis switching and touch toggle.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------------
//  input    | i_in_valid / o_in_stall     | i_op i_temp_sample i_read_ok i_touch_level
//  result   | o_out_valid / i_out_stall   | o_heater_on o_drive_value o_loop_enabled
//           |                             | o_current_temp
//  config   | i_cfg_we                    | i_cfg_index i_cfg_data
//
//  One item per cycle sustained while i_out_stall is low; a result is registered
//  after its item leaves the queue. The rate is set by the execute step in the
//  back end, whose state (heater flag, integral, previous error) feeds the next item.
//  Synchronous active-low reset; the queue is empty and the loop enabled after it.
//  A result stall holds the back end; the front keeps taking items until the
//  two-entry queue is full, and o_in_stall depends only on the queue fill.
// ----------------------------------------------------------------------------
module heater_pid_hysteresis_control (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [hpc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [hpc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [hpc_pkg::OP_W-1:0]              i_op,
    input  logic signed [hpc_pkg::TEMP_W-1:0]     i_temp_sample,
    input  logic                                  i_read_ok,
    input  logic                                  i_touch_level,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_heater_on,
    output logic signed [hpc_pkg::DRIVE_W-1:0]    o_drive_value,
    output logic                                  o_loop_enabled,
    output logic signed [hpc_pkg::TEMP_W-1:0]     o_current_temp
);

    hpc_pkg::t_cmd    w_front_cmd;
    hpc_pkg::t_cmd    w_q_cmd;
    hpc_pkg::t_cfg_wr w_cfg;
    logic             w_push;
    logic             w_pop;
    logic             w_q_full;
    logic             w_q_valid;

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    hpc_front u_front (
        .i_in_valid    (i_in_valid),
        .i_op          (i_op),
        .i_temp_sample (i_temp_sample),
        .i_read_ok     (i_read_ok),
        .i_touch_level (i_touch_level),
        .i_q_full      (w_q_full),
        .o_in_stall    (o_in_stall),
        .o_push        (w_push),
        .o_cmd         (w_front_cmd)
    );

    hpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    hpc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_q_valid      (w_q_valid),
        .i_cmd          (w_q_cmd),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_heater_on    (o_heater_on),
        .o_drive_value  (o_drive_value),
        .o_loop_enabled (o_loop_enabled),
        .o_current_temp (o_current_temp)
    );

endmodule
